// ===== rtl/core/bemc_pkg.sv =====
// ----------------------------------------------------------------------------
// bemc_pkg
// Shared types, widths, codes and reset values for the brushed ESC mode
// controller.
// ----------------------------------------------------------------------------
package bemc_pkg;

    // Field widths
    localparam int THROTTLE_W   = 11;
    localparam int DEADBAND_W   = 10;
    localparam int TICKS_CFG_W  = 16;
    localparam int PKT_IN_W     = 4;
    localparam int TRUTH_W      = 8;
    localparam int BLINK_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Default storage widths for the top level parameters
    localparam int TICK_W_DEF   = 16;
    localparam int PACKET_W_DEF = 8;

    // Tally to exceed in init or no signal before the motor may run
    localparam int NOSIG_MIN_PACKETS = 10;

    // Bridge truth codes
    localparam logic [TRUTH_W-1:0] TRUTH_OFF      = 8'hff;
    localparam logic [TRUTH_W-1:0] TRUTH_LOW_ON   = 8'h01;
    localparam logic [TRUTH_W-1:0] TRUTH_HIGH_FWD = 8'h00;
    localparam logic [TRUTH_W-1:0] TRUTH_HIGH_BWD = 8'h02;

    // LED blink counts
    localparam logic [BLINK_W-1:0] BLINK_NONE  = 3'd0;
    localparam logic [BLINK_W-1:0] BLINK_OFF   = 3'd1;
    localparam logic [BLINK_W-1:0] BLINK_FWD   = 3'd2;
    localparam logic [BLINK_W-1:0] BLINK_BWD   = 3'd3;
    localparam logic [BLINK_W-1:0] BLINK_NOSIG = 3'd4;

    // Configuration reset values
    localparam logic [THROTTLE_W-1:0]  THR_MIN_RST      = 11'd172;
    localparam logic [THROTTLE_W-1:0]  THR_CENTER_RST   = 11'd992;
    localparam logic [DEADBAND_W-1:0]  DEADBAND_RST     = 10'd164;
    localparam logic [THROTTLE_W-1:0]  IN_CENTER_RST    = 11'd992;
    localparam logic [THROTTLE_W-1:0]  PWM_MAX_RST      = 11'd820;
    localparam logic [TICKS_CFG_W-1:0] STATE_TICKS_RST  = 16'd500;
    localparam logic [TICKS_CFG_W-1:0] WINDOW_TICKS_RST = 16'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_MIN      = 3'd0,
        CFG_THR_CENTER   = 3'd1,
        CFG_DEADBAND     = 3'd2,
        CFG_IN_CENTER    = 3'd3,
        CFG_PWM_MAX      = 3'd4,
        CFG_STATE_TICKS  = 3'd5,
        CFG_WINDOW_TICKS = 3'd6
    } cfg_idx_t;

    // Controller modes
    typedef enum logic [2:0] {
        MODE_UNDEF = 3'd0,
        MODE_INIT  = 3'd1,
        MODE_NOSIG = 3'd2,
        MODE_OFF   = 3'd3,
        MODE_FWD   = 3'd4,
        MODE_BWD   = 3'd5
    } mode_t;

    // One rate tick request
    typedef struct packed {
        logic [THROTTLE_W-1:0] throttle;
        logic                  throttle_valid;
        logic [PKT_IN_W-1:0]   new_packets;
    } tick_t;

    // One result per tick
    typedef struct packed {
        mode_t                 mode;
        logic                  mode_changed;
        logic [THROTTLE_W-1:0] duty;
        logic                  duty_written;
        logic [TRUTH_W-1:0]    low_side_truth;
        logic [TRUTH_W-1:0]    high_side_truth;
        logic                  led_steady;
        logic [BLINK_W-1:0]    led_blinks;
    } result_t;

endpackage

// ===== rtl/core/brushed_esc_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// brushed_esc_mode_controller_top
// Mode machine, deadband and duty computation for a brushed motor ESC.
// ----------------------------------------------------------------------------
// Each accepted tick request passes through 11 shift-and-add steps that
// form the reverse duty product one multiplier bit at a time, then 11
// restoring division steps that take one quotient bit each, then a commit
// step that updates the mode, timers and packet tally and loads the result
// register. The sequencer then returns to idle to capture the next request,
// so a new request is accepted only after the last one has been committed.
// The next request is accepted while a result still waits in the output
// register. The commit step holds until that register is
// free. Configuration writes are taken at any time (cfg_ready is always high)
// and belong between ticks.
module brushed_esc_mode_controller_top
    import bemc_pkg::*;
#(
    parameter int TICK_W   = TICK_W_DEF,
    parameter int PACKET_W = PACKET_W_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick requests
    input  logic                  item_valid,
    output logic                  item_stall,
    input  tick_t                 item,
    // results
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W  = (TICK_W > TICKS_CFG_W) ? TICK_W : TICKS_CFG_W;
    localparam int STEP_W = $clog2(THROTTLE_W);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_COMMIT
    } seq_t;

    // configuration
    logic [THROTTLE_W-1:0]  thr_min_reg;
    logic [THROTTLE_W-1:0]  thr_center_reg;
    logic [DEADBAND_W-1:0]  deadband_reg;
    logic [THROTTLE_W-1:0]  in_center_reg;
    logic [THROTTLE_W-1:0]  pwm_max_reg;
    logic [TICKS_CFG_W-1:0] state_ticks_reg;
    logic [TICKS_CFG_W-1:0] window_ticks_reg;

    // controller state
    mode_t                  mode_reg, mode_next;
    logic [TICK_W-1:0]      mode_timer_reg, mode_timer_next;
    logic [TICK_W-1:0]      window_timer_reg, window_timer_next;
    logic [PACKET_W-1:0]    tally_reg, tally_next;
    logic [THROTTLE_W-1:0]  duty_reg, duty_next;
    logic [TRUTH_W-1:0]     low_truth_reg, low_truth_next;
    logic [TRUTH_W-1:0]     high_truth_reg, high_truth_next;

    // sequencer and serial datapath
    seq_t                   seq_reg;
    logic [STEP_W-1:0]      step_reg;
    tick_t                  item_reg;
    logic [THROTTLE_W-1:0]  acc_reg, acc_next;
    logic [THROTTLE_W-1:0]  mplr_reg, mplr_next;
    result_t                result_reg, result_next;
    logic                   result_valid_reg;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_min_reg      <= THR_MIN_RST;
            thr_center_reg   <= THR_CENTER_RST;
            deadband_reg     <= DEADBAND_RST;
            in_center_reg    <= IN_CENTER_RST;
            pwm_max_reg      <= PWM_MAX_RST;
            state_ticks_reg  <= STATE_TICKS_RST;
            window_ticks_reg <= WINDOW_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THR_MIN:      thr_min_reg      <= cfg_data[THROTTLE_W-1:0];
                CFG_THR_CENTER:   thr_center_reg   <= cfg_data[THROTTLE_W-1:0];
                CFG_DEADBAND:     deadband_reg     <= cfg_data[DEADBAND_W-1:0];
                CFG_IN_CENTER:    in_center_reg    <= cfg_data[THROTTLE_W-1:0];
                CFG_PWM_MAX:      pwm_max_reg      <= cfg_data[THROTTLE_W-1:0];
                CFG_STATE_TICKS:  state_ticks_reg  <= cfg_data[TICKS_CFG_W-1:0];
                CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data[TICKS_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Deadband decisions on the captured throttle
    // ------------------------------------------------------------------
    logic [THROTTLE_W:0]   fwd_start;
    logic                  bstart_ok;
    logic [THROTTLE_W-1:0] bwd_start;
    logic                  is_fwd, is_bwd;
    logic [THROTTLE_W-1:0] bwd_dist;
    logic                  span_pos;
    logic [THROTTLE_W-1:0] bwd_span;

    assign fwd_start = (THROTTLE_W+1)'(thr_center_reg) + (THROTTLE_W+1)'(deadband_reg);
    assign bstart_ok = THROTTLE_W'(deadband_reg) <= thr_center_reg;
    assign bwd_start = thr_center_reg - THROTTLE_W'(deadband_reg);
    assign is_fwd    = item_reg.throttle_valid &&
                       ((THROTTLE_W+1)'(item_reg.throttle) >= fwd_start);
    assign is_bwd    = item_reg.throttle_valid && bstart_ok &&
                       (item_reg.throttle <= bwd_start);
    assign bwd_dist  = bwd_start - item_reg.throttle;
    assign span_pos  = bstart_ok && (bwd_start > thr_min_reg);
    assign bwd_span  = bwd_start - thr_min_reg;

    // ------------------------------------------------------------------
    // Serial multiply (dist * pwm_max) then restoring divide by span
    // ------------------------------------------------------------------
    logic [THROTTLE_W:0] mul_sum;
    logic [THROTTLE_W:0] div_trial;
    logic                div_ge;
    logic [THROTTLE_W:0] div_diff;

    always_comb
    begin
        mul_sum   = (THROTTLE_W+1)'(acc_reg) +
                    (mplr_reg[0] ? (THROTTLE_W+1)'(bwd_dist) : '0);
        div_trial = {acc_reg, mplr_reg[THROTTLE_W-1]};
        div_ge    = div_trial >= (THROTTLE_W+1)'(bwd_span);
        div_diff  = div_trial - (THROTTLE_W+1)'(bwd_span);
        acc_next  = acc_reg;
        mplr_next = mplr_reg;
        case (seq_reg)
            SEQ_IDLE:
            begin
                // new request: clear the product and load the multiplier
                if (item_valid)
                begin
                    acc_next  = '0;
                    mplr_next = pwm_max_reg;
                end
            end
            SEQ_MUL:
            begin
                acc_next  = mul_sum[THROTTLE_W:1];
                mplr_next = {mul_sum[0], mplr_reg[THROTTLE_W-1:1]};
            end
            SEQ_DIV:
            begin
                acc_next  = div_ge ? div_diff[THROTTLE_W-1:0]
                                   : div_trial[THROTTLE_W-1:0];
                mplr_next = {mplr_reg[THROTTLE_W-2:0], div_ge};
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Tick update: timers, signal window, mode rules, duty, bridge codes
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]     mt_inc, wt_inc;
    logic [PACKET_W:0]     tally_sum;
    logic [PACKET_W-1:0]   tally_sat;
    logic                  window_hit;
    mode_t                 mode_win;
    logic                  written;
    logic                  changed;
    logic [THROTTLE_W-1:0] fwd_diff;
    logic [THROTTLE_W-1:0] fwd_duty;
    logic [THROTTLE_W-1:0] bwd_duty;
    logic [BLINK_W-1:0]    blinks;

    always_comb
    begin
        mt_inc     = mode_timer_reg + 1'b1;
        wt_inc     = window_timer_reg + 1'b1;
        tally_sum  = (PACKET_W+1)'(tally_reg) + (PACKET_W+1)'(item_reg.new_packets);
        tally_sat  = tally_sum[PACKET_W] ? '1 : tally_sum[PACKET_W-1:0];
        window_hit = CMP_W'(wt_inc) >= CMP_W'(window_ticks_reg);

        // forward duty, clamped to 0..pwm_max
        fwd_diff = item_reg.throttle - in_center_reg;
        if (item_reg.throttle <= in_center_reg)
            fwd_duty = '0;
        else if (fwd_diff > pwm_max_reg)
            fwd_duty = pwm_max_reg;
        else
            fwd_duty = fwd_diff;

        // reverse duty: full scale on empty span or when past the span end
        if (!span_pos || (bwd_dist >= bwd_span))
            bwd_duty = pwm_max_reg;
        else
            bwd_duty = mplr_reg;

        // signal window closes
        mode_win          = mode_reg;
        tally_next        = tally_sat;
        window_timer_next = wt_inc;
        if (window_hit)
        begin
            if (tally_sat == '0)
                mode_win = MODE_NOSIG;
            tally_next        = '0;
            window_timer_next = '0;
        end

        // mode rules
        mode_next = mode_win;
        duty_next = duty_reg;
        written   = 1'b0;
        case (mode_win)
            MODE_UNDEF:
            begin
                if (CMP_W'(mt_inc) >= CMP_W'(state_ticks_reg))
                    mode_next = MODE_INIT;
            end
            MODE_INIT, MODE_NOSIG:
            begin
                if (tally_next > PACKET_W'(NOSIG_MIN_PACKETS))
                    mode_next = MODE_OFF;
            end
            MODE_OFF:
            begin
                if (is_fwd)
                    mode_next = MODE_FWD;
                else if (is_bwd)
                    mode_next = MODE_BWD;
            end
            MODE_FWD:
            begin
                if (!is_fwd)
                    mode_next = MODE_OFF;
                else
                begin
                    duty_next = fwd_duty;
                    written   = 1'b1;
                end
            end
            MODE_BWD:
            begin
                if (!is_bwd)
                    mode_next = MODE_OFF;
                else
                begin
                    duty_next = bwd_duty;
                    written   = 1'b1;
                end
            end
            default: mode_next = MODE_UNDEF;
        endcase

        // mode change restarts the state timer; a change to off, forward or backward reloads the bridge
        changed         = mode_next != mode_reg;
        mode_timer_next = changed ? '0 : mt_inc;
        low_truth_next  = low_truth_reg;
        high_truth_next = high_truth_reg;
        if (changed)
        begin
            case (mode_next)
                MODE_OFF:
                begin
                    low_truth_next  = TRUTH_OFF;
                    high_truth_next = TRUTH_OFF;
                end
                MODE_FWD:
                begin
                    low_truth_next  = TRUTH_LOW_ON;
                    high_truth_next = TRUTH_HIGH_FWD;
                end
                MODE_BWD:
                begin
                    low_truth_next  = TRUTH_LOW_ON;
                    high_truth_next = TRUTH_HIGH_BWD;
                end
                default: ;
            endcase
        end

        // LED pattern
        case (mode_next)
            MODE_NOSIG: blinks = BLINK_NOSIG;
            MODE_OFF:   blinks = BLINK_OFF;
            MODE_FWD:   blinks = BLINK_FWD;
            MODE_BWD:   blinks = BLINK_BWD;
            default:    blinks = BLINK_NONE;
        endcase

        result_next.mode            = mode_next;
        result_next.mode_changed    = changed;
        result_next.duty            = duty_next;
        result_next.duty_written    = written;
        result_next.low_side_truth  = low_truth_next;
        result_next.high_side_truth = high_truth_next;
        result_next.led_steady      = mode_next == MODE_INIT;
        result_next.led_blinks      = blinks;
    end

    // ------------------------------------------------------------------
    // Sequencer, state and result register
    // ------------------------------------------------------------------
    logic out_free;
    logic commit;

    assign out_free = !result_valid_reg || !result_stall;
    assign commit   = (seq_reg == SEQ_COMMIT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= SEQ_IDLE;
            step_reg         <= '0;
            item_reg         <= '0;
            acc_reg          <= '0;
            mplr_reg         <= '0;
            mode_reg         <= MODE_UNDEF;
            mode_timer_reg   <= '0;
            window_timer_reg <= '0;
            tally_reg        <= '0;
            duty_reg         <= '0;
            low_truth_reg    <= TRUTH_OFF;
            high_truth_reg   <= TRUTH_OFF;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            mplr_reg <= mplr_next;

            // result register: filled on commit, emptied when taken
            if (commit)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            case (seq_reg)
                SEQ_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg <= item;
                        step_reg <= '0;
                        seq_reg  <= SEQ_MUL;
                    end
                end
                SEQ_MUL:
                begin
                    if (step_reg == STEP_W'(THROTTLE_W-1))
                    begin
                        step_reg <= '0;
                        seq_reg  <= SEQ_DIV;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                SEQ_DIV:
                begin
                    if (step_reg == STEP_W'(THROTTLE_W-1))
                    begin
                        step_reg <= '0;
                        seq_reg  <= SEQ_COMMIT;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                SEQ_COMMIT:
                begin
                    if (commit)
                    begin
                        mode_reg         <= mode_next;
                        mode_timer_reg   <= mode_timer_next;
                        window_timer_reg <= window_timer_next;
                        tally_reg        <= tally_next;
                        duty_reg         <= duty_next;
                        low_truth_reg    <= low_truth_next;
                        high_truth_reg   <= high_truth_next;
                        result_reg       <= result_next;
                        seq_reg          <= SEQ_IDLE;
                    end
                end
                default: seq_reg <= SEQ_IDLE;
            endcase
        end
    end

    assign item_stall   = seq_reg != SEQ_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/bemc_checker.sv =====
// ----------------------------------------------------------------------------
// bemc_checker
// Port-level checks on the brushed ESC mode controller results.
// ----------------------------------------------------------------------------
module bemc_checker
    import bemc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  result_valid,
    input logic                  result_stall,
    input result_t               result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // steady LED only in init
    a_led_init: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.led_steady == (result.mode == MODE_INIT)))
        else $error("led_steady disagrees with mode");

    // duty only recomputed while running in an unchanged direction
    a_duty_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.duty_written |->
            !result.mode_changed &&
            (result.mode == MODE_FWD || result.mode == MODE_BWD))
        else $error("duty written outside a running mode");

    // bridge codes always form a legal pair
    a_bridge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.low_side_truth == TRUTH_OFF && result.high_side_truth == TRUTH_OFF) ||
            (result.low_side_truth == TRUTH_LOW_ON &&
             (result.high_side_truth == TRUTH_HIGH_FWD ||
              result.high_side_truth == TRUTH_HIGH_BWD)))
        else $error("illegal bridge truth pair");

endmodule

bind brushed_esc_mode_controller_top bemc_checker u_bemc_checker (.*);

// ===== sim/tb_brushed_esc_mode_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brushed_esc_mode_controller_top
// Self-checking bench for the brushed ESC mode controller. Tick requests are
// sent in random bursts while the result side stalls on its own pattern. A
// scoreboard keeps its own mode machine, timers, packet tally and duty, works
// out the result of every accepted tick and compares it field by field with
// what the block returns. The run steps through several register settings,
// the extremes among them, and rewrites them only while the block is idle.
// ----------------------------------------------------------------------------
module tb_brushed_esc_mode_controller_top;
    import bemc_pkg::*;

    localparam int  TALLY_MAX   = (1 << PACKET_W_DEF) - 1;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 48;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the controller state and registers
    // ------------------------------------------------------------------------
    class esc_mode_scoreboard;
        logic [THROTTLE_W-1:0]   thr_min, thr_center, in_center, pwm_max;
        logic [DEADBAND_W-1:0]   deadband;
        logic [TICKS_CFG_W-1:0]  state_ticks, window_ticks;

        mode_t                   mode;
        logic [TICK_W_DEF-1:0]   mode_timer, window_timer;
        logic [PACKET_W_DEF-1:0] tally;
        logic [THROTTLE_W-1:0]   held_duty;
        logic [TRUTH_W-1:0]      low_truth, high_truth;

        result_t                 tick_results_due[$];
        int                      mismatches;

        function new();
            thr_min      = THR_MIN_RST;
            thr_center   = THR_CENTER_RST;
            deadband     = DEADBAND_RST;
            in_center    = IN_CENTER_RST;
            pwm_max      = PWM_MAX_RST;
            state_ticks  = STATE_TICKS_RST;
            window_ticks = WINDOW_TICKS_RST;
            mode         = MODE_UNDEF;
            mode_timer   = '0;
            window_timer = '0;
            tally        = '0;
            held_duty    = '0;
            low_truth    = TRUTH_OFF;
            high_truth   = TRUTH_OFF;
            mismatches   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THR_MIN:      thr_min      = data[THROTTLE_W-1:0];
                CFG_THR_CENTER:   thr_center   = data[THROTTLE_W-1:0];
                CFG_DEADBAND:     deadband     = data[DEADBAND_W-1:0];
                CFG_IN_CENTER:    in_center    = data[THROTTLE_W-1:0];
                CFG_PWM_MAX:      pwm_max      = data[THROTTLE_W-1:0];
                CFG_STATE_TICKS:  state_ticks  = data[TICKS_CFG_W-1:0];
                CFG_WINDOW_TICKS: window_ticks = data[TICKS_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted tick and queue its result
        function void predict_tick(tick_t t);
            longint      thr, fstart, bstart, d, gap, span;
            bit          fwd, bwd, written;
            int unsigned sum;
            mode_t       prev;
            result_t     r;

            thr     = longint'(t.throttle);
            fstart  = longint'(thr_center) + longint'(deadband);
            bstart  = longint'(thr_center) - longint'(deadband);
            fwd     = t.throttle_valid && (thr >= fstart);
            bwd     = t.throttle_valid && (thr <= bstart);
            written = 1'b0;
            prev    = mode;

            mode_timer   = mode_timer + 1'b1;
            window_timer = window_timer + 1'b1;
            sum          = int'(tally) + int'(t.new_packets);
            tally        = (sum > TALLY_MAX) ? TALLY_MAX[PACKET_W_DEF-1:0]
                                             : sum[PACKET_W_DEF-1:0];

            // end of a signal window: no packets at all means no signal
            if (window_timer >= window_ticks)
            begin
                if (tally == 0)
                    mode = MODE_NOSIG;
                tally        = '0;
                window_timer = '0;
            end

            case (mode)
                MODE_UNDEF:
                    if (mode_timer >= state_ticks)
                    begin
                        mode       = MODE_INIT;
                        mode_timer = '0;
                    end
                MODE_INIT, MODE_NOSIG:
                    if (tally > NOSIG_MIN_PACKETS)
                        mode = MODE_OFF;
                MODE_OFF:
                    if (fwd)
                        mode = MODE_FWD;
                    else if (bwd)
                        mode = MODE_BWD;
                MODE_FWD:
                    if (!fwd)
                        mode = MODE_OFF;
                    else
                    begin
                        d = thr - longint'(in_center);
                        if (d < 0)
                            d = 0;
                        if (d > longint'(pwm_max))
                            d = longint'(pwm_max);
                        held_duty = d[THROTTLE_W-1:0];
                        written   = 1'b1;
                    end
                MODE_BWD:
                    if (!bwd)
                        mode = MODE_OFF;
                    else
                    begin
                        gap  = bstart - thr;
                        span = bstart - longint'(thr_min);
                        // empty or inverted span gives full duty
                        if (span <= 0)
                            d = longint'(pwm_max);
                        else
                        begin
                            d = (gap * longint'(pwm_max)) / span;
                            if (d > longint'(pwm_max))
                                d = longint'(pwm_max);
                        end
                        held_duty = d[THROTTLE_W-1:0];
                        written   = 1'b1;
                    end
                default:
                    mode = MODE_UNDEF;
            endcase

            // bridge codes reload on a change of mode only
            if (mode != prev)
            begin
                mode_timer = '0;
                case (mode)
                    MODE_OFF:
                    begin
                        low_truth  = TRUTH_OFF;
                        high_truth = TRUTH_OFF;
                    end
                    MODE_FWD:
                    begin
                        low_truth  = TRUTH_LOW_ON;
                        high_truth = TRUTH_HIGH_FWD;
                    end
                    MODE_BWD:
                    begin
                        low_truth  = TRUTH_LOW_ON;
                        high_truth = TRUTH_HIGH_BWD;
                    end
                    default: ;
                endcase
            end

            r.mode            = mode;
            r.mode_changed    = (mode != prev);
            r.duty            = held_duty;
            r.duty_written    = written;
            r.low_side_truth  = low_truth;
            r.high_side_truth = high_truth;
            r.led_steady      = (mode == MODE_INIT);
            case (mode)
                MODE_NOSIG: r.led_blinks = BLINK_NOSIG;
                MODE_OFF:   r.led_blinks = BLINK_OFF;
                MODE_FWD:   r.led_blinks = BLINK_FWD;
                MODE_BWD:   r.led_blinks = BLINK_BWD;
                default:    r.led_blinks = BLINK_NONE;
            endcase
            tick_results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare an accepted result with the oldest outstanding one
        function void check_result(result_t got);
            result_t want;
            if (tick_results_due.size() == 0)
            begin
                $error("result with no tick awaiting it: mode %0d duty %0d",
                       got.mode, got.duty);
                mismatches++;
                return;
            end
            want = tick_results_due.pop_front();
            compare_field("mode", 16'(want.mode), 16'(got.mode));
            compare_field("mode_changed", 16'(want.mode_changed), 16'(got.mode_changed));
            compare_field("duty", 16'(want.duty), 16'(got.duty));
            compare_field("duty_written", 16'(want.duty_written), 16'(got.duty_written));
            compare_field("low_side_truth", 16'(want.low_side_truth),
                          16'(got.low_side_truth));
            compare_field("high_side_truth", 16'(want.high_side_truth),
                          16'(got.high_side_truth));
            compare_field("led_steady", 16'(want.led_steady), 16'(got.led_steady));
            compare_field("led_blinks", 16'(want.led_blinks), 16'(got.led_blinks));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    tick_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    esc_mode_scoreboard    sb = new();

    int                    cycles     = 0;
    int                    stall_left = 0;
    int                    flow_left  = 0;
    int                    quiet_left = 0;
    int                    burst_left = 0;

    brushed_esc_mode_controller_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: alternating runs of flow and stall
    always @(negedge clk)
    begin
        if (stall_left == 0 && flow_left == 0)
        begin
            flow_left  = $urandom_range(1, 48);
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 4);
        end
        if (stall_left != 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            flow_left--;
            result_stall <= 1'b0;
        end
    end

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    task automatic send_tick(tick_t t);
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= t;
        do
            @(posedge clk);
        while (item_stall);
        sb.predict_tick(t);
    endtask

    task automatic pause_sender(int n);
        repeat (n)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
    endtask

    // Idle the sender until every outstanding tick has produced its result
    task automatic drain();
        pause_sender(1);
        while (sb.tick_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(int tmin, int center, int dead, int incen,
                                int pmax, int sticks, int wticks);
        write_reg(CFG_THR_MIN,      CFG_DATA_W'(tmin));
        write_reg(CFG_THR_CENTER,   CFG_DATA_W'(center));
        write_reg(CFG_DEADBAND,     CFG_DATA_W'(dead));
        write_reg(CFG_IN_CENTER,    CFG_DATA_W'(incen));
        write_reg(CFG_PWM_MAX,      CFG_DATA_W'(pmax));
        write_reg(CFG_STATE_TICKS,  CFG_DATA_W'(sticks));
        write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'(wticks));
    endtask

    function automatic logic [THROTTLE_W-1:0] near_value(longint base);
        longint v;
        v = base + longint'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return v[THROTTLE_W-1:0];
    endfunction

    // Random tick: mostly live packet flow, throttle aimed at the thresholds
    function automatic tick_t random_tick();
        tick_t t;
        int    sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            t.throttle = ($urandom_range(0, 1) != 0) ? '1 : '0;
        else if (sel < 40)
            t.throttle = near_value(longint'(sb.thr_center) + longint'(sb.deadband));
        else if (sel < 65)
            t.throttle = near_value(longint'(sb.thr_center) - longint'(sb.deadband));
        else if (sel < 80)
            t.throttle = near_value(($urandom_range(0, 1) != 0) ? longint'(sb.in_center)
                                                                : longint'(sb.thr_min));
        else
            t.throttle = THROTTLE_W'($urandom_range(0, 2047));
        t.throttle_valid = ($urandom_range(0, 9) != 0);
        // quiet stretches let a whole window pass without packets
        if (quiet_left != 0)
        begin
            quiet_left--;
            t.new_packets = '0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            quiet_left    = $urandom_range(1, 24);
            t.new_packets = '0;
        end
        else if ($urandom_range(0, 9) == 0)
            t.new_packets = '0;
        else
            t.new_packets = PKT_IN_W'($urandom_range(1, 15));
        return t;
    endfunction

    task automatic run_random(int n);
        repeat (n)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                pause_sender($urandom_range(1, 10));
            end
            burst_left--;
            if ($urandom_range(0, 99) == 0)
                drain();
            send_tick(random_tick());
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // short start-up times so the mode machine moves early
        apply_config(172, 992, 164, 992, 820, 2, 6);

        // directed walk: undefined, init, off, forward, backward, no signal
        send_tick('{11'd0,    1'b0, 4'd0});
        send_tick('{11'd2047, 1'b1, 4'd0});
        send_tick('{11'd0,    1'b1, 4'd15});
        send_tick('{11'd2047, 1'b1, 4'd15});
        send_tick('{11'd2047, 1'b1, 4'd15});
        send_tick('{11'd1156, 1'b1, 4'd1});
        send_tick('{11'd1155, 1'b1, 4'd1});
        send_tick('{11'd2047, 1'b0, 4'd1});
        send_tick('{11'd0,    1'b0, 4'd1});
        send_tick('{11'd828,  1'b1, 4'd1});
        send_tick('{11'd828,  1'b1, 4'd1});
        send_tick('{11'd172,  1'b1, 4'd1});
        send_tick('{11'd0,    1'b1, 4'd15});
        send_tick('{11'd500,  1'b1, 4'd2});
        send_tick('{11'd829,  1'b1, 4'd3});
        repeat (7) send_tick('{11'd992, 1'b1, 4'd0});
        send_tick('{11'd992,  1'b1, 4'd15});
        send_tick('{11'd1500, 1'b1, 4'd15});
        run_random(172);

        // zero deadband, zero input centre, widest duty
        apply_config(0, 1024, 0, 0, 2047, 65535, 20);
        run_random(172);

        // inverted reverse span, forward out of reach, narrowest duty
        apply_config(2047, 2047, 1023, 2047, 1, 1, 3);
        run_random(172);

        // deadband wider than the centre, tally saturates in a long window
        apply_config(100, 100, 1023, 500, 820, 9, 65535);
        run_random(172);

        // zero duty limit; window cut below the running count
        apply_config(172, 992, 164, 992, 0, 500, 2);
        run_random(172);

        repeat (2)
        begin
            apply_config($urandom_range(0, 2047), $urandom_range(0, 2047),
                         $urandom_range(0, 1023), $urandom_range(0, 2047),
                         $urandom_range(1, 2047), $urandom_range(1, 65535),
                         $urandom_range(1, 40));
            run_random(172);
        end

        // one-tick window: tally clears on every tick
        apply_config(500, 1000, 10, 1000, 1500, 65535, 1);
        run_random(172);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.mismatches == 0 && sb.tick_results_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
